// ===== rtl/msfs_pkg.sv =====
// ----------------------------------------------------------------------------
// msfs_pkg
// Shared types and constants for the multi-server finish scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package msfs_pkg;

    localparam int MAX_SERVERS = 16;
    localparam int TIME_W      = 32;
    localparam int CNT_W       = $clog2(MAX_SERVERS + 1);
    localparam int CFG_W       = 5;

    typedef logic [TIME_W-1:0] time_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    typedef struct packed {
        time_t arrival_time;
        time_t duration;
        logic  last_task;
    } task_t;

    typedef struct packed {
        time_t finish_time;
        time_t makespan;
        logic  batch_done;
    } result_t;

    typedef struct packed {
        logic  valid;
        time_t value;
    } entry_t;

    typedef enum logic [1:0] {
        OP_NOP = 2'd0,
        OP_POP = 2'd1,
        OP_INS = 2'd2,
        OP_CLR = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        time_t    value;
    } cell_ctrl_t;

    function automatic time_t sat_add(input time_t a, input time_t b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/msfs_cell.sv =====
// ----------------------------------------------------------------------------
// msfs_cell
// One slot of the sorted finish-time chain. Pops from its right neighbor,
// inserts in order by looking at its left neighbor's compare.
// ----------------------------------------------------------------------------
`default_nettype none

module msfs_cell import msfs_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cell_ctrl_t ctrl,
    input  wire entry_t     left,
    input  wire logic       left_gt,
    input  wire entry_t     right,
    output entry_t          ent,
    output logic            gt
);

    logic  valid_reg, valid_next;
    time_t value_reg, value_next;

    // slot is free or holds a later time than the one being inserted
    assign gt = !valid_reg || (value_reg > ctrl.value);

    always_comb
    begin
        valid_next = valid_reg;
        value_next = value_reg;
        case (ctrl.op)
            OP_POP:
            begin
                valid_next = right.valid;
                value_next = right.value;
            end
            OP_INS:
            begin
                if (gt)
                begin
                    if (left_gt)
                    begin
                        valid_next = left.valid;
                        value_next = left.value;
                    end
                    else
                    begin
                        valid_next = 1'b1;
                        value_next = ctrl.value;
                    end
                end
            end
            OP_CLR:
            begin
                valid_next = 1'b0;
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign ent.valid = valid_reg;
    assign ent.value = value_reg;

endmodule

`default_nettype wire

// ===== rtl/msfs_chain.sv =====
// ----------------------------------------------------------------------------
// msfs_chain
// Row of cells kept in ascending order; the head holds the earliest finish.
// ----------------------------------------------------------------------------
`default_nettype none

module msfs_chain import msfs_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cell_ctrl_t ctrl,
    output entry_t          head
);

    entry_t ents [MAX_SERVERS];
    logic   gts  [MAX_SERVERS];

    genvar i;
    generate
        for (i = 0; i < MAX_SERVERS; i++)
        begin : g_cell
            entry_t l_ent, r_ent;
            logic   l_gt;

            if (i == 0)
            begin : g_first
                assign l_ent = '0;
                assign l_gt  = 1'b0;
            end
            else
            begin : g_mid
                assign l_ent = ents[i-1];
                assign l_gt  = gts[i-1];
            end

            if (i == MAX_SERVERS - 1)
            begin : g_last
                assign r_ent = '0;
            end
            else
            begin : g_inner
                assign r_ent = ents[i+1];
            end

            msfs_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctrl    (ctrl),
                .left    (l_ent),
                .left_gt (l_gt),
                .right   (r_ent),
                .ent     (ents[i]),
                .gt      (gts[i])
            );
        end
    endgenerate

    assign head = ents[0];

    generate
        for (i = 1; i < MAX_SERVERS; i++)
        begin : g_chk
            a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
                (ents[i].valid |-> (ents[i-1].valid &&
                                    ents[i-1].value <= ents[i].value)))
                else $error("finish-time chain out of order");
        end
    endgenerate

endmodule

`default_nettype wire

// ===== rtl/multi_server_finish_scheduler_top.sv =====
// ----------------------------------------------------------------------------
// multi_server_finish_scheduler_top
// Dispatches tasks to a server pool, tracking busy finish times in a sorted
// chain of cells; returns each task's finish time and the running makespan.
// ----------------------------------------------------------------------------
// Result strobe: done is registered from S_INS, reached from the start transfer via S_CALC.
// Each task passes a head read/pop step (S_CALC), then an ordered insert (S_INS).
// busy is high only in the pop cycle; a new start is taken during the insert.
// Reset clears the chain valid bits, counts and makespan; pool size = 1.
// The receiver cannot stall: done is a single-cycle strobe.
`default_nettype none

module multi_server_finish_scheduler_top import msfs_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire task_t            task_in,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [CFG_W-1:0] cfg_data,
    output logic                  done,
    output result_t               result
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CALC = 3'b010,
        S_INS  = 3'b100
    } state_t;

    state_t           state_reg, state_next;
    task_t            task_reg;
    time_t            finish_reg, finish_next;
    time_t            largest_reg, largest_next;
    cnt_t             count_reg, count_next;
    logic [CFG_W-1:0] server_count_reg;
    logic             done_reg;
    result_t          result_reg;

    cell_ctrl_t ctrl;
    entry_t     head;
    cnt_t       pool;
    logic       take_free;
    logic       accept;
    time_t      start_time;
    time_t      makespan_new;

    assign busy      = (state_reg == S_CALC);
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        if (server_count_reg == '0)
            pool = cnt_t'(1);
        else if ({{(32-CFG_W){1'b0}}, server_count_reg} > MAX_SERVERS)
            pool = cnt_t'(MAX_SERVERS);
        else
            pool = cnt_t'(server_count_reg);
    end

    assign take_free  = (count_reg < pool) && (count_reg < cnt_t'(MAX_SERVERS));
    assign start_time = (!take_free && head.value > task_reg.arrival_time) ?
                        head.value : task_reg.arrival_time;
    assign finish_next  = sat_add(start_time, task_reg.duration);
    assign makespan_new = (finish_reg > largest_reg) ? finish_reg : largest_reg;

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        largest_next = largest_reg;
        ctrl.op      = OP_NOP;
        ctrl.value   = finish_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_CALC;
            end
            S_CALC:
            begin
                // earliest finish leaves the chain when no server is free
                if (!take_free)
                begin
                    ctrl.op    = OP_POP;
                    count_next = count_reg - cnt_t'(1);
                end
                state_next = S_INS;
            end
            S_INS:
            begin
                if (task_reg.last_task)
                begin
                    ctrl.op      = OP_CLR;
                    count_next   = '0;
                    largest_next = '0;
                end
                else
                begin
                    ctrl.op      = OP_INS;
                    count_next   = count_reg + cnt_t'(1);
                    largest_next = makespan_new;
                end
                state_next = accept ? S_CALC : S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            count_reg        <= '0;
            largest_reg      <= '0;
            server_count_reg <= CFG_W'(1);
            done_reg         <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            largest_reg <= largest_next;
            done_reg    <= (state_reg == S_INS);
            if (cfg_valid && cfg_ready)
                server_count_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            task_reg <= task_in;
        if (state_reg == S_CALC)
            finish_reg <= finish_next;
        if (state_reg == S_INS)
        begin
            result_reg.finish_time <= finish_reg;
            result_reg.makespan    <= makespan_new;
            result_reg.batch_done  <= task_reg.last_task;
        end
    end

    msfs_chain u_chain (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .head  (head)
    );

    assign done   = done_reg;
    assign result = result_reg;

    a_calc_then_ins: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CALC) |=> (state_reg == S_INS))
        else $error("pop cycle not followed by insert");

    a_done_after_ins: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == S_INS))
        else $error("result strobe without insert");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= cnt_t'(MAX_SERVERS))
        else $error("busy count beyond chain length");

    a_makespan_ge: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.makespan >= result.finish_time))
        else $error("makespan below finish time");

    a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) |-> head.valid)
        else $error("chain head empty with servers busy");

endmodule

`default_nettype wire
